// ----- rtl/dq_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
// No dependencies; imported by every module of the block.
package dq_pkg;

    // Default number of slots in the ring
    localparam int DQ_DEPTH = 16;

    // Request operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_BACK  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_BACK   = 2'd3
    } t_dq_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } t_dq_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_RDWAIT = 2'd2,
        S_DONE   = 2'd3
    } t_dq_state;

    // Input item
    typedef struct packed {
        t_dq_func           func;
        logic signed [31:0] push_value;
    } t_dq_in;

    // Result item
    typedef struct packed {
        t_dq_status         status;
        logic signed [31:0] pop_value;
        logic [4:0]         item_count;
        logic               is_empty;
    } t_dq_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic exec;
        logic capture_pop;
    } t_dq_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fail;
        logic is_pop;
    } t_dq_sts;

endpackage

// ----- rtl/dq_ctrl.sv -----
// Sequencing controller for the double-ended queue unit.
// Depends on dq_pkg for state, command and status types.
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  dq_pkg::t_dq_sts  i_sts,
    output dq_pkg::t_dq_cmd  o_cmd
);
    import dq_pkg::*;

    t_dq_state r_state;
    t_dq_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_stall           = 1'b1;
        o_valid           = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.fail || !i_sts.is_pop) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RDWAIT;
                end
            end
            S_RDWAIT: begin
                o_cmd.capture_pop = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Never take an item while a result is pending
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("item accepted while result pending");

    // Execute only right after an accepted item
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> $past(i_valid && !o_stall))
        else $error("execute without accepted item");

    // Pop data capture only right after a successful pop
    a_capture_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture_pop |-> $past(o_cmd.exec && i_sts.is_pop && !i_sts.fail))
        else $error("pop capture without successful pop");

endmodule

// ----- rtl/dq_datapath.sv -----
// Datapath of the double-ended queue: slot memory, front index, count, result register.
// Depends on dq_pkg for payload, command and status types.
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dq_pkg::t_dq_cmd  i_cmd,
    output dq_pkg::t_dq_sts  o_sts,
    input  dq_pkg::t_dq_in   i_req,
    output dq_pkg::t_dq_out  o_res
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    t_dq_in             r_req;
    t_dq_out            r_res;
    logic [AW-1:0]      r_front;
    logic [CW-1:0]      r_count;

    logic [AW-1:0]      n_front;
    logic [CW-1:0]      n_count;
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      front_inc;
    logic [CW-1:0]      back_off;
    logic [SW-1:0]      pos_sum;
    logic [SW-1:0]      pos_wrap;
    logic [AW-1:0]      ring_pos;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               full;
    logic               empty;
    logic               fail;
    logic               is_pop;

    // Ring index arithmetic
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign back_off  = (r_req.func == FUNC_PUSH_BACK) ? r_count : r_count - CW'(1);
    assign pos_sum   = SW'(r_front) + SW'(back_off);
    assign pos_wrap  = (pos_sum >= SW'(DEPTH)) ? pos_sum - SW'(DEPTH) : pos_sum;
    assign ring_pos  = pos_wrap[AW-1:0];

    // Decode the held request
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = ring_pos;
        rd_addr = r_front;
        fail    = 1'b0;
        is_pop  = 1'b0;
        unique case (r_req.func)
            FUNC_PUSH_FRONT: begin
                fail    = full;
                wr_addr = front_dec;
                if (!full) begin
                    wr_en   = 1'b1;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_PUSH_BACK: begin
                fail    = full;
                wr_addr = ring_pos;
                if (!full) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_POP_FRONT: begin
                fail    = empty;
                is_pop  = 1'b1;
                rd_addr = r_front;
                if (!empty) begin
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            FUNC_POP_BACK: begin
                fail    = empty;
                is_pop  = 1'b1;
                rd_addr = ring_pos;
                if (!empty) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                fail = 1'b0;
            end
        endcase
    end

    assign o_sts.fail   = fail;
    assign o_sts.is_pop = is_pop;
    assign o_res        = r_res;

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_req.push_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Front index and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Hold the request and build the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            if (!fail) begin
                r_res.status <= ST_OK;
            end else if (is_pop) begin
                r_res.status <= ST_UNDERFLOW;
            end else begin
                r_res.status <= ST_FULL;
            end
            r_res.pop_value  <= '0;
            r_res.item_count <= 5'(n_count);
            r_res.is_empty   <= (n_count == '0);
        end
        if (i_cmd.capture_pop) begin
            r_res.pop_value <= r_rd_data;
        end
    end

    // Count stays within the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count exceeds depth");

    // Front index stays within the ring
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= AW'(DEPTH - 1))
        else $error("front index out of range");

    // A refused request leaves the queue untouched
    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && fail |=> $stable(r_count) && $stable(r_front))
        else $error("refused request changed the queue");

    // A successful pop drops exactly one item
    a_pop_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !fail && is_pop |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not drop one item");

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// Bounded double-ended queue of signed 32-bit words, stored as a ring of DEPTH slots
// in a single-port-write, registered-read memory with a front index and an item count.
// Each item is a push or pop at either end and yields one result: status (ok, underflow
// on a pop from an empty queue, full on a push to a full queue), the popped word (zero
// otherwise), the count afterwards and an empty flag. One item is in flight at a time:
// a push or a refused request passes through the execute and done states, a successful
// pop also through a read-wait state between them for the memory's registered read. A
// new item is accepted only after the result of the last one has been taken. The slot
// memory needs no clearing after reset.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue_unit #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  dq_pkg::t_dq_in   i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output dq_pkg::t_dq_out  o_res
);
    import dq_pkg::*;

    t_dq_cmd cmd;
    t_dq_sts sts;

    // Request sequencing
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Storage and result
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule
